[hw/rtl/wsp_pkg.sv]
// Package for the wind sentence parser.
// Holds the match phase type, the result struct, character codes and sizes.
// No dependencies.
package wsp_pkg;

    localparam int LINE_BYTES_DEF = 64;
    localparam int VAL_W          = 16;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_Q     = 8'h51;
    localparam logic [7:0] PRINT_LO = 8'h20;
    localparam logic [7:0] PRINT_HI = 8'h7E;

    localparam logic [6:0] SPEED_SCALE = 7'd100;

    typedef enum logic [3:0] {
        PH_Q,
        PH_COMMA,
        PH_DIR_START,
        PH_DIR_SIGN,
        PH_DIR_DIGITS,
        PH_WH_START,
        PH_WH_SIGN,
        PH_WH_DIGITS,
        PH_FR_START,
        PH_FR_SIGN,
        PH_FR_DIGITS,
        PH_DONE,
        PH_FAIL
    } t_phase;

    typedef struct packed {
        logic             emit;
        logic [VAL_W-1:0] dir;
        logic [VAL_W-1:0] speed;
    } t_result;

    // Only the low bits of each accumulator reach the outputs, so they are kept narrow.
    function automatic logic [VAL_W-1:0] push_digit(input logic [VAL_W-1:0] acc,
                                                    input logic [7:0] c);
        push_digit = (acc << 3) + (acc << 1) + VAL_W'(c[3:0]);
    endfunction

endpackage

[hw/rtl/wsp_parser.sv]
// Line state and pattern matcher of the wind sentence parser.
// Updates the match phase and accumulators for one byte and forms the result.
// Depends on wsp_pkg.
module wsp_parser import wsp_pkg::*; #(
    parameter int LINE_BYTES = LINE_BYTES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic       i_advance,
    input  logic [7:0] i_byte,
    output t_result    o_res
);

    localparam int FILL_W = $clog2(LINE_BYTES);

    t_phase           r_phase, n_phase;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic             r_zero, n_zero;
    logic [VAL_W-1:0] r_dir, n_dir;
    logic [VAL_W-1:0] r_whole, n_whole;
    logic [VAL_W-1:0] r_frac, n_frac;
    logic [2:0]       r_sign, n_sign;

    logic             w_digit;
    logic             w_print;
    logic             w_line_end;
    logic [VAL_W-1:0] w_dir_s;
    logic [VAL_W-1:0] w_whole_s;
    logic [VAL_W-1:0] w_frac_s;

    assign w_digit    = i_byte inside {[CH_ZERO:CH_NINE]};
    assign w_print    = i_byte inside {[PRINT_LO:PRINT_HI]};
    assign w_line_end = (i_byte inside {CH_LF, CH_CR}) && (r_fill != '0);

    always_comb begin
        n_phase = r_phase;
        n_fill  = r_fill;
        n_zero  = r_zero;
        n_dir   = r_dir;
        n_whole = r_whole;
        n_frac  = r_frac;
        n_sign  = r_sign;
        if (w_line_end) begin
            n_phase = PH_Q;
            n_fill  = '0;
            n_zero  = 1'b0;
            n_dir   = '0;
            n_whole = '0;
            n_frac  = '0;
            n_sign  = '0;
        end else if (r_fill < FILL_W'(LINE_BYTES - 1)) begin
            n_fill = r_fill + 1'b1;
            if (!r_zero) begin
                if (i_byte == CH_NUL) begin
                    n_zero = 1'b1;
                end else if (w_print) begin
                    case (r_phase)
                        PH_Q: begin
                            n_phase = (i_byte == CH_Q) ? PH_COMMA : PH_FAIL;
                        end
                        PH_COMMA: begin
                            n_phase = (i_byte == CH_COMMA) ? PH_DIR_START : PH_FAIL;
                        end
                        PH_DIR_START: begin
                            if (i_byte == CH_SPACE) begin
                                n_phase = PH_DIR_START;
                            end else if (i_byte == CH_PLUS) begin
                                n_phase = PH_DIR_SIGN;
                            end else if (i_byte == CH_MINUS) begin
                                n_sign[0] = 1'b1;
                                n_phase   = PH_DIR_SIGN;
                            end else if (w_digit) begin
                                n_dir   = push_digit(r_dir, i_byte);
                                n_phase = PH_DIR_DIGITS;
                            end else begin
                                n_phase = PH_FAIL;
                            end
                        end
                        PH_DIR_SIGN, PH_DIR_DIGITS: begin
                            if (w_digit) begin
                                n_dir   = push_digit(r_dir, i_byte);
                                n_phase = PH_DIR_DIGITS;
                            end else if (r_phase == PH_DIR_DIGITS && i_byte == CH_COMMA) begin
                                n_phase = PH_WH_START;
                            end else begin
                                n_phase = PH_FAIL;
                            end
                        end
                        PH_WH_START: begin
                            if (i_byte == CH_SPACE) begin
                                n_phase = PH_WH_START;
                            end else if (i_byte == CH_PLUS) begin
                                n_phase = PH_WH_SIGN;
                            end else if (i_byte == CH_MINUS) begin
                                n_sign[1] = 1'b1;
                                n_phase   = PH_WH_SIGN;
                            end else if (w_digit) begin
                                n_whole = push_digit(r_whole, i_byte);
                                n_phase = PH_WH_DIGITS;
                            end else begin
                                n_phase = PH_FAIL;
                            end
                        end
                        PH_WH_SIGN, PH_WH_DIGITS: begin
                            if (w_digit) begin
                                n_whole = push_digit(r_whole, i_byte);
                                n_phase = PH_WH_DIGITS;
                            end else if (r_phase == PH_WH_DIGITS && i_byte == CH_DOT) begin
                                n_phase = PH_FR_START;
                            end else begin
                                n_phase = PH_FAIL;
                            end
                        end
                        PH_FR_START: begin
                            if (i_byte == CH_SPACE) begin
                                n_phase = PH_FR_START;
                            end else if (i_byte == CH_PLUS) begin
                                n_phase = PH_FR_SIGN;
                            end else if (i_byte == CH_MINUS) begin
                                n_sign[2] = 1'b1;
                                n_phase   = PH_FR_SIGN;
                            end else if (w_digit) begin
                                n_frac  = push_digit(r_frac, i_byte);
                                n_phase = PH_FR_DIGITS;
                            end else begin
                                n_phase = PH_FAIL;
                            end
                        end
                        PH_FR_SIGN: begin
                            if (w_digit) begin
                                n_frac  = push_digit(r_frac, i_byte);
                                n_phase = PH_FR_DIGITS;
                            end else begin
                                n_phase = PH_FAIL;
                            end
                        end
                        PH_FR_DIGITS: begin
                            if (w_digit) begin
                                n_frac = push_digit(r_frac, i_byte);
                            end else begin
                                n_phase = PH_DONE;
                            end
                        end
                        default: begin
                            n_phase = r_phase;
                        end
                    endcase
                end
            end
        end
    end

    always_comb begin
        w_dir_s     = r_sign[0] ? (VAL_W'(0) - r_dir)   : r_dir;
        w_whole_s   = r_sign[1] ? (VAL_W'(0) - r_whole) : r_whole;
        w_frac_s    = r_sign[2] ? (VAL_W'(0) - r_frac)  : r_frac;
        o_res.emit  = i_valid && w_line_end
                      && (r_phase == PH_FR_DIGITS || r_phase == PH_DONE);
        o_res.dir   = w_dir_s;
        o_res.speed = VAL_W'(w_whole_s * SPEED_SCALE) + w_frac_s;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_Q;
            r_fill  <= '0;
            r_zero  <= 1'b0;
            r_dir   <= '0;
            r_whole <= '0;
            r_frac  <= '0;
            r_sign  <= '0;
        end else if (i_advance) begin
            r_phase <= n_phase;
            r_fill  <= n_fill;
            r_zero  <= n_zero;
            r_dir   <= n_dir;
            r_whole <= n_whole;
            r_frac  <= n_frac;
            r_sign  <= n_sign;
        end
    end

endmodule

[hw/rtl/wind_sentence_parser.sv]
// A byte accepted into the input register is parsed there by wsp_parser, and its result, if any,
// is captured in the output register, which drives the output transaction.
// Throughput: one byte per cycle while the input is not stalled; the input register, the single
// parse step in wsp_parser and the output register each advance once per cycle.
// The input stalls only when a line end must place a result while the output is stalled.
// Reset is synchronous and active low; it empties both registers and clears the line state.
// Top level of the wind sentence parser; depends on wsp_pkg and wsp_parser.
module wind_sentence_parser import wsp_pkg::*; #(
    parameter int LINE_BYTES = LINE_BYTES_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [7:0]              i_rx_byte,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic signed [VAL_W-1:0] o_wind_direction,
    output logic signed [VAL_W-1:0] o_wind_speed_hundredths
);

    logic             r_in_valid, n_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_out_valid, n_out_valid;
    logic [VAL_W-1:0] r_out_dir;
    logic [VAL_W-1:0] r_out_speed;

    logic    w_out_free;
    logic    w_take;
    logic    w_in_accept;
    t_result w_res;

    wsp_parser #(
        .LINE_BYTES(LINE_BYTES)
    ) u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (r_in_valid),
        .i_advance (w_take),
        .i_byte    (r_in_byte),
        .o_res     (w_res)
    );

    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_take      = r_in_valid && (!w_res.emit || w_out_free);
    assign o_in_stall  = r_in_valid && !w_take;
    assign w_in_accept = i_in_valid && !o_in_stall;

    always_comb begin
        n_in_valid = r_in_valid;
        if (w_in_accept) begin
            n_in_valid = 1'b1;
        end else if (w_take) begin
            n_in_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (w_take && w_res.emit) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_in_byte <= i_rx_byte;
        end
        if (w_take && w_res.emit) begin
            r_out_dir   <= w_res.dir;
            r_out_speed <= w_res.speed;
        end
    end

    assign o_out_valid             = r_out_valid;
    assign o_wind_direction        = $signed(r_out_dir);
    assign o_wind_speed_hundredths = $signed(r_out_speed);

endmodule

[hw/rtl/wsp_checker.sv]
// Port-level checks for the wind sentence parser, attached by a bind statement.
// Depends on wsp_pkg and the top level wind_sentence_parser.
module wsp_checker import wsp_pkg::*; (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    o_in_stall,
    input logic                    o_out_valid,
    input logic                    i_out_stall,
    input logic signed [VAL_W-1:0] o_wind_direction,
    input logic signed [VAL_W-1:0] o_wind_speed_hundredths
);

    // Reset empties the output register.
    a_reset_out: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output transaction valid after reset");

    // Reset empties the input register, so the input is free afterward.
    a_reset_in: assert property (@(posedge i_clk) !i_rst_n |=> !o_in_stall)
        else $error("input stalled after reset");

    // The input only backs up when a finished result is held by the output.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without a blocked output transaction");

    // A stalled result stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_wind_direction)
                                          && $stable(o_wind_speed_hundredths)))
        else $error("stalled output transaction changed");

endmodule

bind wind_sentence_parser wsp_checker u_wsp_checker (.*);
